// File: rtl/core/trct_pkg.sv
// shared types and constants of the root cluster table
`timescale 1ns / 1ps
package trct_pkg;

  localparam int MAX_ROOTS   = 64;
  localparam int MAX_DIMS    = 4;
  localparam int ID_W        = $clog2(MAX_ROOTS);
  localparam int CNT_W       = $clog2(MAX_ROOTS + 1);
  localparam int DIM_W       = $clog2(MAX_DIMS);
  localparam int COORD_W     = 32;
  localparam int MAG_W       = COORD_W + 1;
  localparam int SUM_W       = COORD_W + 3;
  localparam int TOL_W       = 31;
  localparam int DIMS_CFG_W  = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 152;
  localparam int CADDR_W     = ID_W + DIM_W;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SUBMIT = 2'd1,
    MODE_XLATE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STS_NOT_CONV = 3'd0,
    STS_MATCHED  = 3'd1,
    STS_ADDED    = 3'd2,
    STS_FULL     = 3'd3,
    STS_DONE     = 3'd4,
    STS_RANGE    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_DIMS  = 2'd0,
    CFG_MATCH = 2'd1,
    CFG_ORDER = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_RUN,
    ST_M_RANK,
    ST_P_ID,
    ST_P_ID2,
    ST_P_CMP,
    ST_S_RK,
    ST_S_IR,
    ST_WR,
    ST_T_RD,
    ST_R_ID,
    ST_R_CMP,
    ST_FIN
  } st_e;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [SUM_W-1:0] sum;
  } alu_res_t;

endpackage

// File: rtl/core/trct_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module trct_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/trct_alu.sv
// shared difference, magnitude and accumulate unit
`timescale 1ns / 1ps
module trct_alu
  import trct_pkg::*;
(
  input  logic signed [COORD_W-1:0] a_i,
  input  logic signed [COORD_W-1:0] b_i,
  input  logic        [SUM_W-1:0]   acc_i,
  output alu_res_t                  res_o
);

  logic signed [MAG_W-1:0] diff;

  always_comb begin
    diff       = {a_i[COORD_W-1], a_i} - {b_i[COORD_W-1], b_i};
    res_o.neg  = diff[MAG_W-1];
    res_o.mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    res_o.sum  = acc_i + SUM_W'(res_o.mag);
  end

endmodule

// File: rtl/core/tolerant_root_cluster_table_top.sv
// root cluster table: sequencer, table memories and result register
`timescale 1ns / 1ps
// Each input beat gives one result beat. A submission walks the stored roots
// one component per cycle through a single shared difference unit, fed by the
// one read port of the component memory, in insertion order up to the first
// match; a new root then steps back over stored roots from the top rank to
// find its rank, updates the rank and id-at-rank tables, and stores its
// components. The block takes one beat at a time; tready is high only between
// items. A finished result waits in the output register while the core takes
// the next item, which then holds in its finish state until that register frees.
module tolerant_root_cluster_table_top
  import trct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // converged, index, coord_0, coord_1, coord_2, coord_3, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // root_id, rank, root_coord_0..3, root_count, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [2:0]             m_axis_tuser
);

  st_e                              st_q, st_d;
  logic [CNT_W-1:0]                 n_q, n_d;
  logic [DIM_W-1:0]                 dlast_q, dlast_d;
  logic [DIMS_CFG_W-1:0]            dims_cfg_q;
  logic [TOL_W-1:0]                 mt_q, ot_q;
  logic [MAX_DIMS-1:0][COORD_W-1:0] p_q, p_d;
  logic [ID_W-1:0]                  idx_q, idx_d;
  logic [CNT_W-1:0]                 mi_q, mi_d;
  logic [DIM_W-1:0]                 mj_q, mj_d;
  logic                             rv_q, rv_d, rl_q, rl_d;
  logic [ID_W-1:0]                  ri_q, ri_d;
  logic [DIM_W-1:0]                 rj_q, rj_d;
  logic [SUM_W-1:0]                 acc_q, acc_d;
  logic [CNT_W-1:0]                 pos_q, pos_d;
  logic [ID_W-1:0]                  cid_q, cid_d;
  logic [DIM_W-1:0]                 cj_q, cj_d;
  logic [CNT_W-1:0]                 k_q, k_d;
  logic                             wv_q, wv_d;
  logic [ID_W-1:0]                  wk_q, wk_d;
  status_e                          res_sts_q, res_sts_d;
  logic [ID_W-1:0]                  res_id_q, res_id_d, res_rk_q, res_rk_d;
  logic [MAX_DIMS-1:0][COORD_W-1:0] res_rc_q, res_rc_d;
  logic                             ovalid_q, ovalid_d;
  status_e                          o_sts_q, o_sts_d;
  logic [ID_W-1:0]                  o_id_q, o_id_d, o_rk_q, o_rk_d;
  logic [MAX_DIMS-1:0][COORD_W-1:0] o_rc_q, o_rc_d;
  logic [CNT_W-1:0]                 o_cnt_q, o_cnt_d;

  logic                             c_we;
  logic [CADDR_W-1:0]               c_waddr, c_raddr;
  logic [COORD_W-1:0]               c_wdata, c_rdata;
  logic                             rk_we, ir_we;
  logic [ID_W-1:0]                  rk_waddr, rk_raddr, rk_wdata, rk_rdata;
  logic [ID_W-1:0]                  ir_waddr, ir_raddr, ir_wdata, ir_rdata;

  logic [DIM_W-1:0]                 alu_sel;
  logic [SUM_W-1:0]                 alu_acc;
  alu_res_t                         alu;

  logic                             in_acc;
  mode_e                            in_mode;
  logic                             in_conv;
  logic [ID_W-1:0]                  in_idx;
  logic                             issue;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_mode = mode_e'(s_axis_tuser);
  assign in_conv = s_axis_tdata[0];
  assign in_idx  = s_axis_tdata[ID_W:1];

  trct_ram #(.W(COORD_W), .D(MAX_ROOTS * MAX_DIMS)) u_comp_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  // rank per insertion id
  trct_ram #(.W(ID_W), .D(MAX_ROOTS)) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (rk_we),
    .waddr_i(rk_waddr),
    .wdata_i(rk_wdata),
    .raddr_i(rk_raddr),
    .rdata_o(rk_rdata)
  );

  // insertion id per rank
  trct_ram #(.W(ID_W), .D(MAX_ROOTS)) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (ir_we),
    .waddr_i(ir_waddr),
    .wdata_i(ir_wdata),
    .raddr_i(ir_raddr),
    .rdata_o(ir_rdata)
  );

  trct_alu u_alu (
    .a_i  (p_q[alu_sel]),
    .b_i  (c_rdata),
    .acc_i(alu_acc),
    .res_o(alu)
  );

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = o_sts_q;
  assign m_axis_tdata  = {5'b0, o_cnt_q, o_rc_q[3], o_rc_q[2], o_rc_q[1], o_rc_q[0],
                          o_rk_q, o_id_q};

  always_comb begin
    st_d      = st_q;
    n_d       = n_q;
    dlast_d   = dlast_q;
    p_d       = p_q;
    idx_d     = idx_q;
    mi_d      = mi_q;
    mj_d      = mj_q;
    rv_d      = 1'b0;
    rl_d      = rl_q;
    ri_d      = ri_q;
    rj_d      = rj_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    cid_d     = cid_q;
    cj_d      = cj_q;
    k_d       = k_q;
    wv_d      = 1'b0;
    wk_d      = wk_q;
    res_sts_d = res_sts_q;
    res_id_d  = res_id_q;
    res_rk_d  = res_rk_q;
    res_rc_d  = res_rc_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    o_sts_d   = o_sts_q;
    o_id_d    = o_id_q;
    o_rk_d    = o_rk_q;
    o_rc_d    = o_rc_q;
    o_cnt_d   = o_cnt_q;
    c_we      = 1'b0;
    c_waddr   = {n_q[ID_W-1:0], cj_q};
    c_wdata   = p_q[cj_q];
    c_raddr   = '0;
    rk_we     = 1'b0;
    rk_waddr  = wk_q;
    rk_wdata  = rk_rdata + ID_W'(1);
    rk_raddr  = '0;
    ir_we     = 1'b0;
    ir_waddr  = wk_q;
    ir_wdata  = ir_rdata;
    ir_raddr  = '0;
    alu_sel   = '0;
    alu_acc   = '0;
    issue     = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        rk_raddr = in_idx;
        ir_raddr = in_idx;
        if (in_acc) begin
          for (int j = 0; j < MAX_DIMS; j++) begin
            p_d[j] = s_axis_tdata[1 + ID_W + COORD_W*j +: COORD_W];
          end
          idx_d     = in_idx;
          res_sts_d = STS_DONE;
          res_id_d  = '0;
          res_rk_d  = '0;
          res_rc_d  = '0;
          if (dims_cfg_q == '0) begin
            dlast_d = '0;
          end else if (dims_cfg_q > DIMS_CFG_W'(MAX_DIMS)) begin
            dlast_d = DIM_W'(MAX_DIMS - 1);
          end else begin
            dlast_d = DIM_W'(dims_cfg_q - DIMS_CFG_W'(1));
          end
          unique case (in_mode)
            MODE_CLEAR: begin
              n_d  = '0;
              st_d = ST_FIN;
            end
            MODE_SUBMIT: begin
              if (!in_conv) begin
                res_sts_d = STS_NOT_CONV;
                st_d      = ST_FIN;
              end else if (n_q == '0) begin
                pos_d = '0;
                st_d  = ST_P_ID;
              end else begin
                mi_d = '0;
                mj_d = '0;
                st_d = ST_M_RUN;
              end
            end
            MODE_XLATE: begin
              if (CNT_W'(in_idx) < n_q) begin
                st_d = ST_T_RD;
              end else begin
                res_sts_d = STS_RANGE;
                st_d      = ST_FIN;
              end
            end
            MODE_READ: begin
              if (CNT_W'(in_idx) < n_q) begin
                st_d = ST_R_ID;
              end else begin
                res_sts_d = STS_RANGE;
                st_d      = ST_FIN;
              end
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end

      ST_M_RUN: begin
        // issue one component read a cycle, reduce the beat read last cycle
        issue   = (mi_q < n_q);
        c_raddr = {mi_q[ID_W-1:0], mj_q};
        if (issue) begin
          rv_d = 1'b1;
          ri_d = mi_q[ID_W-1:0];
          rj_d = mj_q;
          rl_d = (mj_q == dlast_q);
          if (mj_q == dlast_q) begin
            mj_d = '0;
            mi_d = mi_q + CNT_W'(1);
          end else begin
            mj_d = mj_q + DIM_W'(1);
          end
        end
        alu_sel  = rj_q;
        alu_acc  = (rj_q == '0) ? '0 : acc_q;
        rk_raddr = ri_q;
        if (rv_q) begin
          acc_d = alu.sum;
          if (rl_q) begin
            if (alu.sum <= SUM_W'(mt_q)) begin
              res_sts_d = STS_MATCHED;
              res_id_d  = ri_q;
              st_d      = ST_M_RANK;
            end else if (CNT_W'(ri_q) == n_q - CNT_W'(1)) begin
              if (n_q >= CNT_W'(MAX_ROOTS)) begin
                res_sts_d = STS_FULL;
                st_d      = ST_FIN;
              end else begin
                pos_d = n_q;
                st_d  = ST_P_ID;
              end
            end
          end
        end
      end

      ST_M_RANK: begin
        res_rk_d = rk_rdata;
        st_d     = ST_FIN;
      end

      ST_P_ID: begin
        ir_raddr = ID_W'(pos_q - CNT_W'(1));
        if (pos_q == '0) begin
          k_d  = '0;
          st_d = ST_S_RK;
        end else begin
          st_d = ST_P_ID2;
        end
      end

      ST_P_ID2: begin
        cid_d   = ir_rdata;
        c_raddr = {ir_rdata, dlast_q};
        cj_d    = dlast_q;
        st_d    = ST_P_CMP;
      end

      ST_P_CMP: begin
        // highest component first, small differences are skipped
        alu_sel = cj_q;
        c_raddr = {cid_q, cj_q - DIM_W'(1)};
        if (alu.mag >= MAG_W'(ot_q)) begin
          if (alu.neg) begin
            pos_d = pos_q - CNT_W'(1);
            st_d  = ST_P_ID;
          end else begin
            k_d  = '0;
            st_d = ST_S_RK;
          end
        end else if (cj_q == '0) begin
          k_d  = '0;
          st_d = ST_S_RK;
        end else begin
          cj_d = cj_q - DIM_W'(1);
        end
      end

      ST_S_RK: begin
        // raise every rank at or above the new position
        issue    = (k_q < n_q);
        rk_raddr = k_q[ID_W-1:0];
        if (issue) begin
          wv_d = 1'b1;
          wk_d = k_q[ID_W-1:0];
          k_d  = k_q + CNT_W'(1);
        end
        rk_we = wv_q && (CNT_W'(rk_rdata) >= pos_q);
        if (!issue && !wv_q) begin
          k_d  = n_q;
          st_d = ST_S_IR;
        end
      end

      ST_S_IR: begin
        // move ids at ranks pos..n-1 up by one, top first
        issue    = (k_q > pos_q);
        ir_raddr = ID_W'(k_q - CNT_W'(1));
        if (issue) begin
          wv_d = 1'b1;
          wk_d = k_q[ID_W-1:0];
          k_d  = k_q - CNT_W'(1);
        end
        ir_we = wv_q;
        if (!issue && !wv_q) begin
          cj_d = '0;
          st_d = ST_WR;
        end
      end

      ST_WR: begin
        c_we = 1'b1;
        if (cj_q == '0) begin
          rk_we    = 1'b1;
          rk_waddr = n_q[ID_W-1:0];
          rk_wdata = pos_q[ID_W-1:0];
          ir_we    = 1'b1;
          ir_waddr = pos_q[ID_W-1:0];
          ir_wdata = n_q[ID_W-1:0];
        end
        if (cj_q == DIM_W'(MAX_DIMS - 1)) begin
          n_d       = n_q + CNT_W'(1);
          res_sts_d = STS_ADDED;
          res_id_d  = n_q[ID_W-1:0];
          res_rk_d  = pos_q[ID_W-1:0];
          st_d      = ST_FIN;
        end else begin
          cj_d = cj_q + DIM_W'(1);
        end
      end

      ST_T_RD: begin
        res_id_d = idx_q;
        res_rk_d = rk_rdata;
        st_d     = ST_FIN;
      end

      ST_R_ID: begin
        cid_d   = ir_rdata;
        c_raddr = {ir_rdata, DIM_W'(0)};
        cj_d    = '0;
        st_d    = ST_R_CMP;
      end

      ST_R_CMP: begin
        res_rc_d[cj_q] = c_rdata;
        c_raddr        = {cid_q, cj_q + DIM_W'(1)};
        if (cj_q == dlast_q) begin
          res_id_d = cid_q;
          res_rk_d = idx_q;
          st_d     = ST_FIN;
        end else begin
          cj_d = cj_q + DIM_W'(1);
        end
      end

      ST_FIN: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          o_sts_d  = res_sts_q;
          o_id_d   = res_id_q;
          o_rk_d   = res_rk_q;
          o_rc_d   = res_rc_q;
          o_cnt_d  = n_q;
          st_d     = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      n_q        <= '0;
      ovalid_q   <= 1'b0;
      rv_q       <= 1'b0;
      wv_q       <= 1'b0;
      dims_cfg_q <= DIMS_CFG_W'(2);
      mt_q       <= TOL_W'(6554);
      ot_q       <= TOL_W'(66);
    end else begin
      st_q     <= st_d;
      n_q      <= n_d;
      ovalid_q <= ovalid_d;
      rv_q     <= rv_d;
      wv_q     <= wv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_DIMS:  dims_cfg_q <= cfg_data_i[DIMS_CFG_W-1:0];
          CFG_MATCH: mt_q       <= cfg_data_i[TOL_W-1:0];
          CFG_ORDER: ot_q       <= cfg_data_i[TOL_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dlast_q   <= dlast_d;
    p_q       <= p_d;
    idx_q     <= idx_d;
    mi_q      <= mi_d;
    mj_q      <= mj_d;
    rl_q      <= rl_d;
    ri_q      <= ri_d;
    rj_q      <= rj_d;
    acc_q     <= acc_d;
    pos_q     <= pos_d;
    cid_q     <= cid_d;
    cj_q      <= cj_d;
    k_q       <= k_d;
    wk_q      <= wk_d;
    res_sts_q <= res_sts_d;
    res_id_q  <= res_id_d;
    res_rk_q  <= res_rk_d;
    res_rc_q  <= res_rc_d;
    o_sts_q   <= o_sts_d;
    o_id_q    <= o_id_d;
    o_rk_q    <= o_rk_d;
    o_rc_q    <= o_rc_d;
    o_cnt_q   <= o_cnt_d;
  end

endmodule

// File: rtl/core/trct_checker.sv
// port level checks of the root cluster table, bound to the top level
`timescale 1ns / 1ps
module trct_checker
  import trct_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [CFG_DATA_W-1:0]  cfg_data_i,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]             m_axis_tuser
);

  // a result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[146:140] <= 7'(MAX_ROOTS))
    else $error("root count beyond table size");

  // a matched or added id lies inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STS_MATCHED || m_axis_tuser == STS_ADDED)
    |-> 7'(m_axis_tdata[5:0]) < m_axis_tdata[146:140])
    else $error("root id not below root count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STS_RANGE |-> m_axis_tdata[139:0] == '0)
    else $error("out of range result carries data");

endmodule

bind tolerant_root_cluster_table_top trct_checker u_trct_checker (.*);

// File: bench/tolerant_root_cluster_table_top_test.sv
// stream-level test of the root cluster table against a behavioural predictor
`timescale 1ns / 1ps
module tolerant_root_cluster_table_top_test;
  import trct_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  root_id;
    logic [5:0]  rank;
    logic [31:0] rc0;
    logic [31:0] rc1;
    logic [31:0] rc2;
    logic [31:0] rc3;
    logic [6:0]  count;
  } root_beat_t;

  class root_table_sb;
    int unsigned dims_reg;
    longint      match_tol;
    longint      order_tol;
    longint      comp [MAX_ROOTS][MAX_DIMS];
    int unsigned rank_of [MAX_ROOTS];
    int unsigned stored;
    root_beat_t  pending [$];
    int          errors;

    function new();
      dims_reg  = 2;
      match_tol = 6554;
      order_tol = 66;
      stored    = 0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [30:0] val);
      case (idx)
        CFG_DIMS:  dims_reg  = 32'(val[2:0]);
        CFG_MATCH: match_tol = longint'(val);
        CFG_ORDER: order_tol = longint'(val);
        default: ;
      endcase
    endfunction

    function int unsigned dims_eff();
      if (dims_reg < 1) return 1;
      if (dims_reg > MAX_DIMS) return MAX_DIMS;
      return dims_reg;
    endfunction

    function int unsigned id_at(int unsigned r);
      for (int unsigned i = 0; i < stored; i++)
        if (rank_of[i] == r) return i;
      return 0;
    endfunction

    // point sorts ahead of root r: highest component first, near-equal ones skipped
    function bit ahead_of(longint p [MAX_DIMS], int unsigned r, int unsigned d);
      longint dif;
      for (int j = d - 1; j >= 0; j--) begin
        dif = p[j] - comp[r][j];
        if ((dif < 0 ? -dif : dif) >= order_tol) return dif < 0;
      end
      return 0;
    endfunction

    function void note_input(mode_e mode, bit conv, logic [5:0] idx,
                             logic [31:0] c [MAX_DIMS]);
      root_beat_t  e;
      longint      p [MAX_DIMS];
      longint      l1_sum;
      int unsigned d, pos, r;
      bit          found;
      d = dims_eff();
      e = '0;
      e.status = STS_DONE;
      for (int j = 0; j < MAX_DIMS; j++) p[j] = longint'($signed(c[j]));
      case (mode)
        MODE_CLEAR: stored = 0;
        MODE_SUBMIT: begin
          if (!conv) begin
            e.status = STS_NOT_CONV;
          end else begin
            found = 0;
            for (int unsigned i = 0; i < stored && !found; i++) begin
              l1_sum = 0;
              for (int j = 0; j < d; j++)
                l1_sum += (p[j] - comp[i][j]) < 0 ? comp[i][j] - p[j] : p[j] - comp[i][j];
              if (l1_sum <= match_tol) begin
                found     = 1;
                e.status  = STS_MATCHED;
                e.root_id = 6'(i);
                e.rank    = 6'(rank_of[i]);
              end
            end
            if (!found) begin
              if (stored >= MAX_ROOTS) begin
                e.status = STS_FULL;
              end else begin
                pos = stored;
                while (pos > 0 && ahead_of(p, id_at(pos - 1), d)) pos--;
                for (int unsigned i = 0; i < stored; i++)
                  if (rank_of[i] >= pos) rank_of[i]++;
                for (int j = 0; j < MAX_DIMS; j++) comp[stored][j] = p[j];
                rank_of[stored] = pos;
                e.status  = STS_ADDED;
                e.root_id = 6'(stored);
                e.rank    = 6'(pos);
                stored++;
              end
            end
          end
        end
        MODE_XLATE: begin
          if (idx < stored) begin
            e.root_id = idx;
            e.rank    = 6'(rank_of[idx]);
          end else begin
            e.status = STS_RANGE;
          end
        end
        default: begin
          if (idx < stored) begin
            r = id_at(idx);
            e.root_id = 6'(r);
            e.rank    = idx;
            e.rc0 = 32'(comp[r][0]);
            if (d > 1) e.rc1 = 32'(comp[r][1]);
            if (d > 2) e.rc2 = 32'(comp[r][2]);
            if (d > 3) e.rc3 = 32'(comp[r][3]);
          end else begin
            e.status = STS_RANGE;
          end
        end
      endcase
      e.count = 7'(stored);
      pending.insert(pending.size(), e);
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(root_beat_t act);
      root_beat_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("status", 32'(e.status), 32'(act.status));
      check_field("root_id", 32'(e.root_id), 32'(act.root_id));
      check_field("rank", 32'(e.rank), 32'(act.rank));
      check_field("root_coord_0", e.rc0, act.rc0);
      check_field("root_coord_1", e.rc1, act.rc1);
      check_field("root_coord_2", e.rc2, act.rc2);
      check_field("root_coord_3", e.rc3, act.rc3);
      check_field("root_count", 32'(e.count), 32'(act.count));
    endfunction
  endclass

  logic                   clk_i = 0;
  logic                   rst_ni = 0;
  logic                   cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;

  tolerant_root_cluster_table_top u_dut (.*);

  always #2 clk_i = ~clk_i;

  root_table_sb sb = new();
  int           src_idle = 0;
  int           sink_stall = 0;
  int           quiet_cycles = 0;
  logic [31:0]  recent [$];

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  always @(posedge clk_i) begin
    root_beat_t act;
    if (m_axis_tvalid && m_axis_tready) begin
      act.status  = m_axis_tuser;
      act.root_id = m_axis_tdata[5:0];
      act.rank    = m_axis_tdata[11:6];
      act.rc0     = m_axis_tdata[43:12];
      act.rc1     = m_axis_tdata[75:44];
      act.rc2     = m_axis_tdata[107:76];
      act.rc3     = m_axis_tdata[139:108];
      act.count   = m_axis_tdata[146:140];
      sb.check_result(act);
    end
  end

  always @(posedge clk_i) begin
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(mode_e mode, bit conv, logic [5:0] idx, logic [31:0] c [MAX_DIMS]);
    if ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {1'b0, c[3], c[2], c[1], c[0], idx, conv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(mode, conv, idx, c);
    if (mode == MODE_SUBMIT && conv) begin
      recent.insert(recent.size(), c[0]); recent.insert(recent.size(), c[1]);
      recent.insert(recent.size(), c[2]); recent.insert(recent.size(), c[3]);
      if (recent.size() > 4 * MAX_ROOTS)
        repeat (4) void'(recent.pop_front());
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [30:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i   <= 0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(0, 400000) - 200000;
    endcase
  endfunction

  task automatic random_item();
    logic [31:0] c [MAX_DIMS];
    int          sel, base;
    sel = $urandom_range(0, 99);
    for (int j = 0; j < MAX_DIMS; j++) c[j] = pick_coord();
    // half the converged submissions land near an earlier submitted point, once there is one
    if (sel < 30 && recent.size() >= 4) begin
      base = 4 * $urandom_range(0, recent.size() / 4 - 1);
      for (int j = 0; j < MAX_DIMS; j++)
        c[j] = recent[base + j] + $urandom_range(0, 4000) - 2000;
      send_beat(MODE_SUBMIT, 1, 6'($urandom()), c);
    end else if (sel < 60) send_beat(MODE_SUBMIT, 1, 6'($urandom()), c);
    else if (sel < 66) send_beat(MODE_SUBMIT, 0, 6'($urandom()), c);
    else if (sel < 82) send_beat(MODE_XLATE, 1'($urandom()), 6'($urandom()), c);
    else if (sel < 99) send_beat(MODE_READ, 1'($urandom()), 6'($urandom()), c);
    else send_beat(MODE_CLEAR, 1'($urandom()), 6'($urandom()), c);
  endtask

  initial begin
    logic [31:0] c [MAX_DIMS];
    logic [30:0] dims_set [7];
    logic [30:0] match_set [7];
    logic [30:0] order_set [7];
    dims_set  = '{2, 1, 4, 3, 4, 0, 7};
    match_set = '{6554, 0, 31'h7fff_ffff, 31'($urandom()), 65536, 3000, 20000};
    order_set = '{66, 0, 31'h7fff_ffff, 31'($urandom()), 100, 31'h7fff_ffff, 5000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, extremes, matches, lookups
    c = '{0, 0, 0, 0};
    send_beat(MODE_XLATE, 0, 0, c);
    send_beat(MODE_READ, 0, 63, c);
    send_beat(MODE_SUBMIT, 0, 0, c);
    send_beat(MODE_SUBMIT, 1, 0, c);
    send_beat(MODE_SUBMIT, 1, 0, c);
    c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_beat(MODE_SUBMIT, 1, 63, c);
    c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_beat(MODE_SUBMIT, 1, 0, c);
    c = '{32'h8000_0000, 32'h7fff_ffff, 0, 0};
    send_beat(MODE_SUBMIT, 1, 0, c);
    c = '{100, 20, 0, 0};
    send_beat(MODE_SUBMIT, 1, 0, c);
    c = '{10000, 30, 0, 0};
    send_beat(MODE_SUBMIT, 1, 0, c);
    for (int i = 0; i < 6; i++) send_beat(MODE_READ, 0, 6'(i), c);
    send_beat(MODE_XLATE, 1, 2, c);
    send_beat(MODE_XLATE, 1, 6, c);
    send_beat(MODE_XLATE, 1, 63, c);
    send_beat(MODE_CLEAR, 1, 63, c);
    send_beat(MODE_READ, 1, 0, c);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_reg(CFG_DIMS, dims_set[ph]);
      write_reg(CFG_MATCH, match_set[ph]);
      write_reg(CFG_ORDER, order_set[ph]);
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 51; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 51; end
        default: begin src_idle = 30; sink_stall = 30; end
      endcase
      repeat (175) random_item();
    end

    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// File: sim.f
rtl/core/trct_pkg.sv
rtl/core/trct_ram.sv
rtl/core/trct_alu.sv
rtl/core/tolerant_root_cluster_table_top.sv
rtl/core/trct_checker.sv
bench/tolerant_root_cluster_table_top_test.sv
